// ===== design/assert_macros.svh =====
// Shared assertion macros. Every check is clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define CHECK_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define CHECK_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

`endif

// ===== design/s2i_pkg.sv =====
package s2i_pkg;

    localparam int OffsetBits  = 16;
    localparam int QueueDepth  = 4;
    localparam int BaseBits    = 6;
    localparam int CfgAddrBits = 2;

    localparam logic [CfgAddrBits-1:0] AddrBaseSelect = '0;
    localparam logic [BaseBits-1:0]    BaseReset      = 6'd10;

    localparam logic signed [63:0] ValueMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ValueMin = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } char_word_t;

    typedef struct packed {
        logic signed [63:0]      value;
        logic [OffsetBits-1:0]   end_offset;
        logic                    overflowed;
        logic                    bad_base;
    } result_t;

    // One classified character as handed from the front end to the back end.
    typedef struct packed {
        logic [BaseBits-1:0] digit;
        logic                is_space;
        logic                is_plus;
        logic                is_minus;
        logic                is_zero;
        logic                is_x;
        logic                last;
        logic                first;
        logic [BaseBits-1:0] base;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/s2i_front.sv =====
module s2i_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  s2i_pkg::char_word_t           char_in,
    input  logic [s2i_pkg::BaseBits-1:0]  base_select,
    input  s2i_pkg::q_status_t            q_status,
    output logic                          full,
    output logic                          tok_push,
    output s2i_pkg::token_t               tok
);

    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharMinus = 8'h2D;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5A;
    localparam logic [7:0] CharUpX   = 8'h58;
    localparam logic [7:0] CharLowA  = 8'h61;
    localparam logic [7:0] CharLowZ  = 8'h7A;
    localparam logic [7:0] CharLowX  = 8'h78;
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharCr    = 8'h0D;
    localparam logic [s2i_pkg::BaseBits-1:0] DigitNone = '1;

    logic       first_reg;
    logic       first_next;
    logic [7:0] c;
    logic [7:0] digit_wide;

    assign full     = q_status.full;
    assign tok_push = push && !q_status.full;

    // The first character of a string latches the base register into its word.
    assign first_next = tok_push ? char_in.last_char : first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        c          = char_in.char_byte;
        digit_wide = '1;
        if (c inside {[CharZero:CharNine]})
        begin
            digit_wide = c - CharZero;
        end
        else if (c inside {[CharLowA:CharLowZ]})
        begin
            digit_wide = c - CharLowA + 8'd10;
        end
        else if (c inside {[CharUpA:CharUpZ]})
        begin
            digit_wide = c - CharUpA + 8'd10;
        end

        tok.digit    = (digit_wide == '1) ? DigitNone : digit_wide[s2i_pkg::BaseBits-1:0];
        tok.is_space = (c == CharSpace) || (c inside {[CharTab:CharCr]});
        tok.is_plus  = (c == CharPlus);
        tok.is_minus = (c == CharMinus);
        tok.is_zero  = (c == CharZero);
        tok.is_x     = (c == CharLowX) || (c == CharUpX);
        tok.last     = char_in.last_char;
        tok.first    = first_reg;
        tok.base     = base_select;
    end

endmodule

// ===== design/s2i_queue.sv =====
module s2i_queue
#(
    parameter int DEPTH = s2i_pkg::QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  s2i_pkg::token_t    wr_data,
    input  logic               rd_en,
    output s2i_pkg::token_t    rd_data,
    output s2i_pkg::q_status_t status
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    s2i_pkg::token_t      mem_reg [DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   wr_ptr_next;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_next;
    logic [CntBits-1:0]   count_reg;
    logic [CntBits-1:0]   count_next;

    assign status.full  = (count_reg == CntBits'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/s2i_back.sv =====
module s2i_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  s2i_pkg::token_t    tok,
    input  s2i_pkg::q_status_t q_status,
    input  logic               pop,
    output logic               tok_pop,
    output logic               empty,
    output s2i_pkg::result_t   result
);

    localparam int OB = s2i_pkg::OffsetBits;
    localparam int BB = s2i_pkg::BaseBits;

    localparam logic [2:0] PhSpace  = 3'd0;
    localparam logic [2:0] PhSigned = 3'd1;
    localparam logic [2:0] PhZero   = 3'd2;
    localparam logic [2:0] PhDigits = 3'd3;
    localparam logic [2:0] PhDone   = 3'd4;

    localparam logic [BB-1:0] BaseAuto  = 6'd0;
    localparam logic [BB-1:0] BaseOne   = 6'd1;
    localparam logic [BB-1:0] BaseTwo   = 6'd2;
    localparam logic [BB-1:0] BaseOct   = 6'd8;
    localparam logic [BB-1:0] BaseDec   = 6'd10;
    localparam logic [BB-1:0] BaseHex   = 6'd16;
    localparam logic [BB-1:0] BaseTop   = 6'd36;

    localparam logic [63:0] LimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LimitNeg = 64'h8000_0000_0000_0000;

    logic [2:0]    phase_reg, phase_next;
    logic [63:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [BB-1:0] base_reg, base_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] stop_reg, stop_next;
    logic          sat_reg, sat_next;
    logic          out_valid_reg, out_valid_next;
    s2i_pkg::result_t result_reg, result_next;

    logic [2:0]    step_phase;
    logic [63:0]   step_mag;
    logic          step_neg;
    logic [BB-1:0] step_base;
    logic [OB-1:0] step_stop;
    logic          step_sat;
    logic [OB-1:0] pos_inc;
    logic [BB-1:0] base_cur;
    logic [BB-1:0] final_base;
    logic [OB-1:0] final_stop;
    logic [63:0]   limit;
    logic [70:0]   prod;
    logic          first_path;
    logic          take;
    logic          go;
    logic          bad;
    s2i_pkg::result_t res;

    // The final character of a string waits only while the previous result is still held.
    assign go      = !q_status.empty && (!tok.last || !out_valid_reg || pop);
    assign tok_pop = go;
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        base_cur   = tok.first ? tok.base : base_reg;
        step_phase = phase_reg;
        step_mag   = mag_reg;
        step_neg   = neg_reg;
        step_base  = base_cur;
        step_stop  = stop_reg;
        step_sat   = sat_reg;
        first_path = 1'b0;
        take       = 1'b0;

        case (phase_reg)
            PhSpace:
            begin
                if (tok.is_space)
                begin
                    step_phase = PhSpace;
                end
                else if (tok.is_plus || tok.is_minus)
                begin
                    step_neg   = tok.is_minus;
                    step_phase = PhSigned;
                end
                else
                begin
                    first_path = 1'b1;
                end
            end
            PhSigned:
            begin
                first_path = 1'b1;
            end
            PhZero:
            begin
                if (tok.is_x)
                begin
                    step_base  = BaseHex;
                    step_phase = PhDigits;
                end
                else
                begin
                    step_base = BaseOct;
                    take      = 1'b1;
                end
            end
            PhDigits:
            begin
                take = 1'b1;
            end
            default:
            begin
                step_phase = phase_reg;
            end
        endcase

        // With automatic base, a leading zero is held back until the next character decides.
        if (first_path)
        begin
            if (base_cur == BaseAuto)
            begin
                if (tok.is_zero)
                begin
                    step_phase = PhZero;
                end
                else
                begin
                    step_base = BaseDec;
                    take      = 1'b1;
                end
            end
            else
            begin
                take = 1'b1;
            end
        end

        limit = step_neg ? LimitNeg : LimitPos;
        prod  = 71'(mag_reg) * 71'(step_base) + 71'(tok.digit);

        if (take)
        begin
            if ((step_base < BaseTwo) || (tok.digit >= step_base))
            begin
                step_stop  = pos_reg;
                step_phase = PhDone;
            end
            else
            begin
                if (prod > 71'(limit))
                begin
                    step_mag = limit;
                    step_sat = 1'b1;
                end
                else
                begin
                    step_mag = prod[63:0];
                end
                step_phase = PhDigits;
            end
        end

        pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        final_base = (step_phase == PhZero) ? BaseOct : step_base;
        final_stop = (step_phase == PhDone) ? step_stop : pos_inc;
        bad        = (final_base == BaseOne) || (final_base > BaseTop);

        if (bad)
        begin
            res.value      = '0;
            res.end_offset = '0;
            res.overflowed = 1'b0;
            res.bad_base   = 1'b1;
        end
        else
        begin
            res.value      = step_neg ? $signed(64'd0 - step_mag) : $signed(step_mag);
            res.end_offset = final_stop;
            res.overflowed = step_sat;
            res.bad_base   = 1'b0;
        end

        phase_next = phase_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        sat_next   = sat_reg;
        if (go)
        begin
            if (tok.last)
            begin
                phase_next = PhSpace;
                mag_next   = '0;
                neg_next   = 1'b0;
                base_next  = BaseAuto;
                pos_next   = '0;
                stop_next  = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                phase_next = step_phase;
                mag_next   = step_mag;
                neg_next   = step_neg;
                base_next  = step_base;
                pos_next   = pos_inc;
                stop_next  = step_stop;
                sat_next   = step_sat;
            end
        end

        out_valid_next = (out_valid_reg && !pop) || (go && tok.last);
        result_next    = (go && tok.last) ? res : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PhSpace;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            base_reg      <= BaseAuto;
            pos_reg       <= '0;
            stop_reg      <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            stop_reg      <= stop_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ===== design/string_to_integer_parser.sv =====
// Parses a signed 64-bit integer from a character stream in the manner of strtoll, one
// character per word. A word is taken in every cycle while full is low: the front end
// classifies the character and places it in a small queue (QUEUE_DEPTH words), and the back
// end retires one character per cycle with a single 64 by 6 bit multiply-accumulate, which
// sets the sustained rate of one character per clock while no result waits to be popped.
// A string's result is registered onto the result port once its last character leaves the queue;
// if an earlier result has not been popped, the back end holds the last character of the
// next string and the queue fills behind it. The base register is sampled when the first
// character of a string is pushed, so a write in the middle of a string applies to the next.
`include "assert_macros.svh"

module string_to_integer_parser
#(
    parameter int QUEUE_DEPTH = s2i_pkg::QueueDepth
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  s2i_pkg::char_word_t                 char_in,
    output logic                                empty,
    input  logic                                pop,
    output s2i_pkg::result_t                    result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [s2i_pkg::CfgAddrBits-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [s2i_pkg::BaseBits-1:0] base_select_reg;
    logic [s2i_pkg::BaseBits-1:0] base_select_next;
    logic                         cfg_write;
    logic                         tok_push;
    logic                         tok_pop;
    s2i_pkg::token_t              tok_in;
    s2i_pkg::token_t              tok_out;
    s2i_pkg::q_status_t           q_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == s2i_pkg::AddrBaseSelect);
    assign base_select_next = cfg_write ? pwdata[s2i_pkg::BaseBits-1:0] : base_select_reg;
    assign prdata = (paddr == s2i_pkg::AddrBaseSelect) ? 32'(base_select_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg <= s2i_pkg::BaseReset;
        end
        else
        begin
            base_select_reg <= base_select_next;
        end
    end

    s2i_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .char_in     (char_in),
        .base_select (base_select_reg),
        .q_status    (q_status),
        .full        (full),
        .tok_push    (tok_push),
        .tok         (tok_in)
    );

    s2i_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_data (tok_in),
        .rd_en   (tok_pop),
        .rd_data (tok_out),
        .status  (q_status)
    );

    s2i_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok      (tok_out),
        .q_status (q_status),
        .pop      (pop),
        .tok_pop  (tok_pop),
        .empty    (empty),
        .result   (result)
    );

    `CHECK_ALWAYS(a_queue_state, !(q_status.full && q_status.empty))
    `CHECK_IMPLIES(a_push_gated, tok_push, !q_status.full)
    `CHECK_IMPLIES(a_bad_base_zero, !empty && result.bad_base,
        (result.value == 64'sd0) && !result.overflowed && (result.end_offset == '0))
    `CHECK_IMPLIES(a_saturated_value, !empty && result.overflowed,
        (result.value == s2i_pkg::ValueMax) || (result.value == s2i_pkg::ValueMin))

endmodule

// ===== verif/string_to_integer_parser_checker.sv =====
`timescale 1ns / 100ps

module string_to_integer_parser_checker
    import s2i_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  char_word_t             char_in,
    input  logic                   empty,
    input  logic                   pop,
    input  result_t                result,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CfgAddrBits-1:0] paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    output int                     errors,
    output int                     pending
);

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_DONE
    } scan_phase_t;

    localparam logic [63:0] POSITIVE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEGATIVE_LIMIT = 64'h8000_0000_0000_0000;
    localparam int unsigned NOT_A_DIGIT = 99;

    logic [BaseBits-1:0]   selected_base;
    scan_phase_t           scan;
    logic [63:0]           magnitude_acc;
    bit                    negative;
    logic [BaseBits-1:0]   string_base;
    logic [OffsetBits-1:0] position;
    logic [OffsetBits-1:0] stop_position;
    bit                    saturated;
    result_t               expected_results[$];
    int                    mismatches;

    function automatic int unsigned digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "a" && c <= "z")
        begin
            return c - "a" + 10;
        end
        if (c >= "A" && c <= "Z")
        begin
            return c - "A" + 10;
        end
        return NOT_A_DIGIT;
    endfunction

    task automatic clear_scan();
        scan          = SCAN_SPACE;
        magnitude_acc = '0;
        negative      = 1'b0;
        string_base   = '0;
        position      = '0;
        stop_position = '0;
        saturated     = 1'b0;
    endtask

    task automatic take_digit(input logic [7:0] c);
        int unsigned d;
        logic [63:0] limit;
        d     = digit_value(c);
        limit = negative ? NEGATIVE_LIMIT : POSITIVE_LIMIT;
        if (string_base < 2 || d >= string_base)
        begin
            stop_position = position;
            scan          = SCAN_DONE;
        end
        else
        begin
            // The magnitude limit is one larger on the negative side.
            if (magnitude_acc > (limit - d) / string_base)
            begin
                magnitude_acc = limit;
                saturated     = 1'b1;
            end
            else
            begin
                magnitude_acc = magnitude_acc * string_base + d;
            end
            scan = SCAN_DIGITS;
        end
    endtask

    task automatic take_first(input logic [7:0] c);
        if (string_base == 0 && c == "0")
        begin
            scan = SCAN_ZERO;
        end
        else
        begin
            if (string_base == 0)
            begin
                string_base = 10;
            end
            take_digit(c);
        end
    endtask

    task automatic parse_char(input char_word_t w);
        logic [7:0] c;
        result_t    r;
        c = w.char_byte;
        if (position == 0)
        begin
            string_base = selected_base;
        end
        case (scan)
            SCAN_SPACE:
            begin
                if (c == "+" || c == "-")
                begin
                    negative = (c == "-");
                    scan     = SCAN_SIGNED;
                end
                else if (!(c == 8'd32 || (c >= 8'd9 && c <= 8'd13)))
                begin
                    take_first(c);
                end
            end
            SCAN_SIGNED:
            begin
                take_first(c);
            end
            SCAN_ZERO:
            begin
                if (c == "x" || c == "X")
                begin
                    string_base = 16;
                    scan        = SCAN_DIGITS;
                end
                else
                begin
                    string_base = 8;
                    take_digit(c);
                end
            end
            SCAN_DIGITS:
            begin
                take_digit(c);
            end
            default:
            begin
            end
        endcase
        if (position != '1)
        begin
            position = position + 1'b1;
        end
        if (w.last_char)
        begin
            // The end of the string terminates a parse still in progress.
            if (scan != SCAN_DONE)
            begin
                if (scan == SCAN_ZERO)
                begin
                    string_base = 8;
                end
                stop_position = position;
            end
            if (string_base == 1 || string_base > 36)
            begin
                r.value      = '0;
                r.end_offset = '0;
                r.overflowed = 1'b0;
                r.bad_base   = 1'b1;
            end
            else
            begin
                r.value      = negative ? -magnitude_acc : magnitude_acc;
                r.end_offset = stop_position;
                r.overflowed = saturated;
                r.bad_base   = 1'b0;
            end
            expected_results.push_back(r);
            clear_scan();
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result word with none expected: value %0d", got.value);
            mismatches++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.value !== want.value)
            begin
                $error("value: expected %0d, got %0d", want.value, got.value);
                mismatches++;
            end
            if (got.end_offset !== want.end_offset)
            begin
                $error("end_offset: expected %0d, got %0d", want.end_offset, got.end_offset);
                mismatches++;
            end
            if (got.overflowed !== want.overflowed)
            begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
                mismatches++;
            end
            if (got.bad_base !== want.bad_base)
            begin
                $error("bad_base: expected %0b, got %0b", want.bad_base, got.bad_base);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selected_base = BaseReset;
            clear_scan();
            expected_results.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == AddrBaseSelect)
            begin
                selected_base = pwdata[BaseBits-1:0];
            end
            if (pop && !empty)
            begin
                check_result(result);
            end
            if (push && !full)
            begin
                parse_char(char_in);
            end
            errors  <= mismatches;
            pending <= expected_results.size();
        end
    end

endmodule

// ===== verif/string_to_integer_parser_test.sv =====
`timescale 1ns / 100ps

module string_to_integer_parser_test;

    import s2i_pkg::*;

    localparam int PHASE_COUNT = 12;
    localparam int PHASE_CHARS = 160;
    localparam int CALM_PHASE  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    char_word_t             char_in = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    result_t                result;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CfgAddrBits-1:0] paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int fail_count;
    int results_outstanding;
    bit calm = 1'b0;
    int chars_sent = 0;
    int pop_stall_left = 0;

    always #1 clk = ~clk;

    string_to_integer_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .char_in (char_in),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    string_to_integer_parser_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .char_in (char_in),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (fail_count),
        .pending (results_outstanding)
    );

    // Result side: random bursts of stalls on pop, none in the calm part.
    always @(negedge clk)
    begin
        if (calm)
        begin
            pop <= 1'b1;
        end
        else if (pop_stall_left > 0)
        begin
            pop_stall_left = pop_stall_left - 1;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            pop_stall_left = $urandom_range(0, 8);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] c, input bit last_flag);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
        end
        @(negedge clk);
        push    <= 1'b1;
        char_in <= '{char_byte: c, last_char: last_flag};
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Waits until every expected result has been popped and the pipeline has drained.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_base(input logic [BaseBits-1:0] base);
        settle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrBaseSelect;
        pwdata  <= 32'(base);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input int unsigned v);
        if (v < 10)
        begin
            return 8'(v + 48);
        end
        return $urandom_range(0, 1) ? 8'(v - 10 + 97) : 8'(v - 10 + 65);
    endfunction

    function automatic string limit_text(input int unsigned k);
        case (k)
            0:       return "9223372036854775807";
            1:       return "-9223372036854775808";
            2:       return "9223372036854775808";
            3:       return "-9223372036854775809";
            4:       return "7fffffffffffffff";
            5:       return "-8000000000000000";
            6:       return "0x7FFFFFFFFFFFFFFF";
            7:       return "-0x8000000000000000";
            8:       return "-0X8000000000000001";
            9:       return "1777777777777777777777";
            10:      return "-1000000000000000000000";
            default: return "-zzzzzzzzzzzzz";
        endcase
    endfunction

    task automatic send_random_string(input logic [BaseBits-1:0] base_sel);
        logic [7:0]  text[$];
        string       s;
        int unsigned radix;
        int          count;
        int          pick;
        int unsigned v;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            // Noise: arbitrary bytes.
            count = $urandom_range(1, 8);
            repeat (count) text.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick == 2)
        begin
            s = limit_text($urandom_range(0, 11));
            for (int i = 0; i < s.len(); i++)
            begin
                text.push_back(s[i]);
            end
        end
        else
        begin
            if (base_sel >= 2 && base_sel <= 36)
            begin
                radix = base_sel;
            end
            else if (base_sel == 0)
            begin
                radix = 10;
            end
            else
            begin
                radix = $urandom_range(2, 36);
            end
            count = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
            repeat (count)
            begin
                pick = $urandom_range(0, 6);
                text.push_back(pick >= 5 ? 8'd32 : 8'(9 + pick));
            end
            pick = $urandom_range(0, 3);
            if (pick == 0)
            begin
                text.push_back("+");
            end
            else if (pick == 1)
            begin
                text.push_back("-");
            end
            pick = $urandom_range(0, 3);
            if ((base_sel == 0 || base_sel == 16) && pick == 0)
            begin
                text.push_back("0");
                text.push_back($urandom_range(0, 1) ? "x" : "X");
                radix = 16;
            end
            else if (pick == 1)
            begin
                text.push_back("0");
                if (base_sel == 0)
                begin
                    radix = 8;
                end
            end
            pick = $urandom_range(0, 7);
            count = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(14, 24) : $urandom_range(1, 6);
            repeat (count)
            begin
                v = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 35) : $urandom_range(0, radix - 1);
                text.push_back(digit_char(v));
            end
            pick = $urandom_range(0, 3);
            if (pick == 1)
            begin
                text.push_back(8'h00);
            end
            else if (pick == 2)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick == 3)
            begin
                text.push_back(8'd32);
            end
            count = $urandom_range(0, 2);
            repeat (count) text.push_back(8'($urandom_range(0, 255)));
            if (text.size() == 0)
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    initial
    begin
        logic [BaseBits-1:0] phase_base;
        int                  target;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Base 10 out of reset: whitespace and sign, sign alone, early stop, bare NUL, NUL in digits.
        send_text("\011\012\013\014\015 -42");
        send_text("+");
        send_text("9x");
        send_char(8'h00, 1'b1);
        send_char("5", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("6", 1'b1);
        // Automatic base: hex prefix, lone zero, octal, prefix with no digits.
        write_base(6'd0);
        send_text("0x1F");
        send_text("0");
        send_text("017");
        send_text("0X");
        // An explicit base 16 takes the zero as a digit and stops at the x.
        write_base(6'd16);
        send_text("0x1f");
        write_base(6'd36);
        send_text("zzzzzzzzzzzzz");
        write_base(6'd2);
        send_text("12");
        write_base(6'd1);
        send_text("5");
        write_base(6'd63);
        send_text("9");

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       phase_base = 6'd10;
                1:       phase_base = 6'd0;
                2:       phase_base = 6'd16;
                3:       phase_base = 6'd2;
                4:       phase_base = 6'd36;
                5:       phase_base = 6'd8;
                6:       phase_base = 6'd1;
                7:       phase_base = 6'd37;
                8:       phase_base = 6'd63;
                9:       phase_base = 6'd0;
                10:      phase_base = 6'($urandom_range(0, 63));
                default: phase_base = 6'd10;
            endcase
            if (p == CALM_PHASE)
            begin
                calm = 1'b1;
            end
            write_base(phase_base);
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target)
            begin
                send_random_string(phase_base);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS string_to_integer_parser");
        end
        else
        begin
            $display("FAIL string_to_integer_parser");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL string_to_integer_parser");
        $finish;
    end

endmodule
